### design/frt_pkg.sv
// ----------------------------------------------------------------------------
// frt_pkg
// Field widths, operation codes, status codes and register indexes shared by
// the fragment reassembly tracker, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package frt_pkg;

	// item field widths
	localparam int MODE_W       = 2;
	localparam int GEN_W        = 32;
	localparam int MLEN_W       = 24;
	localparam int OFF_W        = 24;
	localparam int FLEN_W       = 16;
	localparam int FREED_W      = 3;

	// result field widths
	localparam int STATUS_W     = 3;
	localparam int SLOT_OUT_W   = 2;
	localparam int CLEN_W       = 17;
	localparam int ADDR_W       = 18;
	localparam int CNT_W        = 32;
	localparam int LARGEST_W    = 24;

	// configuration port
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;

	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// item operations
	localparam mode_t MODE_FRAGMENT = 2'd0;
	localparam mode_t MODE_RELEASE  = 2'd1;
	localparam mode_t MODE_RESET    = 2'd2;

	// result status
	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_COMPLETE  = 3'd1;
	localparam status_t ST_INVALID   = 3'd2;
	localparam status_t ST_BOUNDS    = 3'd3;
	localparam status_t ST_NO_SLOT   = 3'd4;
	localparam status_t ST_SEQ_ERROR = 3'd5;
	localparam status_t ST_RESTARTED = 3'd6;

	// register indexes
	localparam cfg_idx_t CFG_CURRENT_GENERATION = 2'd0;
	localparam cfg_idx_t CFG_LINK_UP            = 2'd1;

endpackage

### design/frt_if.sv
// ----------------------------------------------------------------------------
// frt channel interfaces
// Valid/ready channels for fragment descriptors, results and register writes.
// ----------------------------------------------------------------------------
interface frt_item_if;
	logic                        valid;
	logic                        ready;
	logic [frt_pkg::MODE_W-1:0]  mode;
	logic [frt_pkg::GEN_W-1:0]   frag_generation;
	logic [frt_pkg::MLEN_W-1:0]  message_length;
	logic [frt_pkg::OFF_W-1:0]   fragment_offset;
	logic [frt_pkg::FLEN_W-1:0]  fragment_length;
	logic [frt_pkg::FREED_W-1:0] freed_slot;

	modport source (output valid, mode, frag_generation, message_length,
		fragment_offset, fragment_length, freed_slot, input ready);
	modport sink (input valid, mode, frag_generation, message_length,
		fragment_offset, fragment_length, freed_slot, output ready);
	modport mon (input valid, ready, mode, frag_generation, message_length,
		fragment_offset, fragment_length, freed_slot);
endinterface

interface frt_result_if;
	logic                           valid;
	logic                           ready;
	logic                           accepted;
	logic [frt_pkg::STATUS_W-1:0]   status;
	logic                           message_done;
	logic [frt_pkg::SLOT_OUT_W-1:0] slot_index;
	logic [frt_pkg::CLEN_W-1:0]     completed_length;
	logic [frt_pkg::ADDR_W-1:0]     write_address;
	logic [frt_pkg::CNT_W-1:0]      dropped_total;
	logic [frt_pkg::CNT_W-1:0]      sequence_error_total;
	logic [frt_pkg::LARGEST_W-1:0]  largest_seen;

	modport source (output valid, accepted, status, message_done, slot_index,
		completed_length, write_address, dropped_total, sequence_error_total,
		largest_seen, input ready);
	modport sink (input valid, accepted, status, message_done, slot_index,
		completed_length, write_address, dropped_total, sequence_error_total,
		largest_seen, output ready);
	modport mon (input valid, ready, accepted, status, message_done, slot_index,
		completed_length, write_address, dropped_total, sequence_error_total,
		largest_seen);
endinterface

interface frt_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [frt_pkg::CFG_IDX_W-1:0]  index;
	logic [frt_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
	modport mon (input valid, ready, index, data);
endinterface

### design/fragment_reassembly_tracker_core.sv
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_core
// Checks fragment descriptors against the live connection, tracks one open
// capture over a fixed pool of slots and reports write addresses, completions
// and drop and sequence error counts.
//
//   channel   dir   handshake        carries
//   item      in    valid / ready    mode, generation, lengths, offset, slot
//   result    out   valid / ready    status, address, completion, counters
//   cfg       in    valid / ready    register index, write data
//
// one item per cycle sustained while results are not stalled; a result is
// valid once its item has passed the input register, then the result register
// the state update of an item happens in one pass between those registers
// a stalled result holds the input register; the item channel keeps taking
// items as long as the input register can move on
// reset clears the capture, all slots, the counters, the configuration and
// the valid flags
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_core #(
	parameter int SLOT_COUNT = 4,
	parameter int SLOT_BYTES = 65536
) (
	input logic       clk,
	input logic       arst_n,
	frt_item_if.sink   item,
	frt_result_if.source result,
	frt_cfg_if.sink    cfg
);

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
	localparam int SUM_W  = frt_pkg::OFF_W + 1;
	localparam int WIDE_W = 32;

	// configuration
	logic [frt_pkg::GEN_W-1:0] cur_gen_q;
	logic                      link_up_q;

	// input register
	logic                        valid_s1;
	logic [frt_pkg::MODE_W-1:0]  mode_s1;
	logic [frt_pkg::GEN_W-1:0]   gen_s1;
	logic [frt_pkg::MLEN_W-1:0]  mlen_s1;
	logic [frt_pkg::OFF_W-1:0]   off_s1;
	logic [frt_pkg::FLEN_W-1:0]  flen_s1;
	logic [frt_pkg::FREED_W-1:0] freed_s1;

	// capture state
	logic                      capture_open_q;
	logic [SLOT_W-1:0]         capture_slot_q;
	logic [LEN_W-1:0]          bytes_recv_q;
	logic [LEN_W-1:0]          bytes_exp_q;
	logic [frt_pkg::GEN_W-1:0] capture_gen_q;
	logic [SLOT_COUNT-1:0]     slot_busy_q;
	logic [frt_pkg::CNT_W-1:0] drop_cnt_q;
	logic [frt_pkg::CNT_W-1:0] seq_cnt_q;
	logic [frt_pkg::LARGEST_W-1:0] largest_q;

	logic                      capture_open_nxt;
	logic [SLOT_W-1:0]         capture_slot_nxt;
	logic [LEN_W-1:0]          bytes_recv_nxt;
	logic [LEN_W-1:0]          bytes_exp_nxt;
	logic [frt_pkg::GEN_W-1:0] capture_gen_nxt;
	logic [SLOT_COUNT-1:0]     slot_busy_nxt;
	logic [frt_pkg::CNT_W-1:0] drop_cnt_nxt;
	logic [frt_pkg::CNT_W-1:0] seq_cnt_nxt;
	logic [frt_pkg::LARGEST_W-1:0] largest_nxt;

	// result register
	logic                           res_valid_q;
	logic                           res_acc_q;
	frt_pkg::status_t               res_status_q;
	logic                           res_done_q;
	logic [frt_pkg::SLOT_OUT_W-1:0] res_slot_q;
	logic [frt_pkg::CLEN_W-1:0]     res_clen_q;
	logic [frt_pkg::ADDR_W-1:0]     res_addr_q;

	// one pass of logic
	logic                           res_acc;
	frt_pkg::status_t               res_status;
	logic                           res_done;
	logic [frt_pkg::CLEN_W-1:0]     res_clen;
	logic [1:0]                     drop_inc;
	logic                           seq_inc;
	logic [SLOT_COUNT-1:0]          busy_abort;
	logic                           free_found;
	logic [SLOT_W-1:0]              free_slot;
	logic                           take;
	logic [SLOT_W-1:0]              take_slot;
	logic [SUM_W-1:0]               sum_end;
	logic [WIDE_W-1:0]              addr_full;
	logic [frt_pkg::FREED_W:0]      freed_ext;
	logic                           desc_invalid;
	logic                           out_of_bounds;
	logic                           out_of_order;
	logic                           advance;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	assign sum_end   = SUM_W'(off_s1) + SUM_W'(flen_s1);
	assign addr_full = WIDE_W'(take_slot) * WIDE_W'(SLOT_BYTES) + WIDE_W'(off_s1);
	assign freed_ext = {1'b0, freed_s1};

	assign desc_invalid = (mlen_s1 == '0) || (flen_s1 == '0) ||
		(gen_s1 != cur_gen_q) || !link_up_q;
	// offset plus length beyond the message covers an offset past the end too
	assign out_of_bounds = (SUM_W'(mlen_s1) > SUM_W'(SLOT_BYTES)) ||
		(sum_end > SUM_W'(mlen_s1));
	assign out_of_order = !capture_open_q ||
		(frt_pkg::MLEN_W'(bytes_exp_q) != mlen_s1) ||
		(capture_gen_q != gen_s1) ||
		(frt_pkg::OFF_W'(bytes_recv_q) != off_s1);

	always_comb begin
		busy_abort = slot_busy_q;
		if (capture_open_q) begin
			busy_abort[capture_slot_q] = 1'b0;
		end
		// lowest free slot wins
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!busy_abort[i]) begin
				free_found = 1'b1;
				free_slot  = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		capture_open_nxt = capture_open_q;
		capture_slot_nxt = capture_slot_q;
		bytes_recv_nxt   = bytes_recv_q;
		bytes_exp_nxt    = bytes_exp_q;
		capture_gen_nxt  = capture_gen_q;
		slot_busy_nxt    = slot_busy_q;
		largest_nxt      = largest_q;
		res_acc          = 1'b0;
		res_status       = frt_pkg::ST_OK;
		res_done         = 1'b0;
		res_clen         = '0;
		drop_inc         = 2'd0;
		seq_inc          = 1'b0;
		take             = 1'b0;
		take_slot        = '0;
		case (mode_s1)
			frt_pkg::MODE_FRAGMENT: begin
				if (desc_invalid) begin
					drop_inc   = 2'd1;
					res_status = frt_pkg::ST_INVALID;
				end else begin
					if (mlen_s1 > largest_q) begin
						largest_nxt = mlen_s1;
					end
					if (out_of_bounds) begin
						drop_inc   = 2'd1;
						res_status = frt_pkg::ST_BOUNDS;
					end else if (off_s1 == '0) begin
						if (capture_open_q) begin
							drop_inc   = 2'd1;
							seq_inc    = 1'b1;
							res_status = frt_pkg::ST_RESTARTED;
						end
						slot_busy_nxt    = busy_abort;
						capture_open_nxt = 1'b0;
						capture_slot_nxt = '0;
						bytes_recv_nxt   = '0;
						bytes_exp_nxt    = '0;
						capture_gen_nxt  = '0;
						if (!free_found) begin
							drop_inc   = drop_inc + 2'd1;
							res_status = frt_pkg::ST_NO_SLOT;
						end else begin
							slot_busy_nxt[free_slot] = 1'b1;
							take      = 1'b1;
							take_slot = free_slot;
						end
					end else if (out_of_order) begin
						drop_inc         = 2'd1;
						seq_inc          = 1'b1;
						res_status       = frt_pkg::ST_SEQ_ERROR;
						slot_busy_nxt    = busy_abort;
						capture_open_nxt = 1'b0;
						capture_slot_nxt = '0;
						bytes_recv_nxt   = '0;
						bytes_exp_nxt    = '0;
						capture_gen_nxt  = '0;
					end else begin
						take      = 1'b1;
						take_slot = capture_slot_q;
					end
					// an in-order fragment always ends at offset plus length
					if (take) begin
						res_acc = 1'b1;
						if (sum_end == SUM_W'(mlen_s1)) begin
							res_done         = 1'b1;
							res_clen         = mlen_s1[frt_pkg::CLEN_W-1:0];
							res_status       = frt_pkg::ST_COMPLETE;
							capture_open_nxt = 1'b0;
							capture_slot_nxt = '0;
							bytes_recv_nxt   = '0;
							bytes_exp_nxt    = '0;
							capture_gen_nxt  = '0;
						end else begin
							capture_open_nxt = 1'b1;
							capture_slot_nxt = take_slot;
							bytes_recv_nxt   = LEN_W'(sum_end);
							bytes_exp_nxt    = LEN_W'(mlen_s1);
							capture_gen_nxt  = gen_s1;
						end
					end
				end
			end
			frt_pkg::MODE_RELEASE: begin
				if (freed_ext < (frt_pkg::FREED_W + 1)'(SLOT_COUNT)) begin
					slot_busy_nxt[freed_s1[SLOT_W-1:0]] = 1'b0;
				end
			end
			frt_pkg::MODE_RESET: begin
				slot_busy_nxt    = busy_abort;
				capture_open_nxt = 1'b0;
				capture_slot_nxt = '0;
				bytes_recv_nxt   = '0;
				bytes_exp_nxt    = '0;
				capture_gen_nxt  = '0;
			end
			default: begin
			end
		endcase
		drop_cnt_nxt = drop_cnt_q + frt_pkg::CNT_W'(drop_inc);
		seq_cnt_nxt  = seq_cnt_q + frt_pkg::CNT_W'(seq_inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_gen_q <= '0;
			link_up_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				frt_pkg::CFG_CURRENT_GENERATION: cur_gen_q <= cfg.data;
				frt_pkg::CFG_LINK_UP:            link_up_q <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			mode_s1  <= item.mode;
			gen_s1   <= item.frag_generation;
			mlen_s1  <= item.message_length;
			off_s1   <= item.fragment_offset;
			flen_s1  <= item.fragment_length;
			freed_s1 <= item.freed_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_open_q <= 1'b0;
			capture_slot_q <= '0;
			bytes_recv_q   <= '0;
			bytes_exp_q    <= '0;
			capture_gen_q  <= '0;
			slot_busy_q    <= '0;
			drop_cnt_q     <= '0;
			seq_cnt_q      <= '0;
			largest_q      <= '0;
		end else if (advance) begin
			capture_open_q <= capture_open_nxt;
			capture_slot_q <= capture_slot_nxt;
			bytes_recv_q   <= bytes_recv_nxt;
			bytes_exp_q    <= bytes_exp_nxt;
			capture_gen_q  <= capture_gen_nxt;
			slot_busy_q    <= slot_busy_nxt;
			drop_cnt_q     <= drop_cnt_nxt;
			seq_cnt_q      <= seq_cnt_nxt;
			largest_q      <= largest_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_acc_q    <= res_acc;
			res_status_q <= res_status;
			res_done_q   <= res_done;
			res_clen_q   <= res_clen;
			// slot and address read as zero unless the bytes are written
			res_slot_q   <= take ? frt_pkg::SLOT_OUT_W'(3'(take_slot)) : '0;
			res_addr_q   <= take ? addr_full[frt_pkg::ADDR_W-1:0] : '0;
		end
	end

	assign result.valid                = res_valid_q;
	assign result.accepted             = res_acc_q;
	assign result.status               = res_status_q;
	assign result.message_done         = res_done_q;
	assign result.slot_index           = res_slot_q;
	assign result.completed_length     = res_clen_q;
	assign result.write_address        = res_addr_q;
	assign result.dropped_total        = drop_cnt_q;
	assign result.sequence_error_total = seq_cnt_q;
	assign result.largest_seen         = largest_q;

endmodule

### design/frt_checker.sv
// ----------------------------------------------------------------------------
// frt_checker
// Port-level checks on the fragment reassembly tracker: result hold under
// stall, result latency and consistency of the result fields.
// ----------------------------------------------------------------------------
module frt_checker (
	input logic          clk,
	input logic          arst_n,
	frt_item_if.sink     item,
	frt_result_if.source result,
	frt_cfg_if.sink      cfg
);

	// a stalled result keeps its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.status) &&
			$stable(result.write_address) && $stable(result.dropped_total))
		else $error("result changed while stalled");

	// a fresh result follows an item taken through the input and result registers
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(item.valid && item.ready, 2))
		else $error("result without an item two cycles before");

	// completion only on an accepted fragment
	a_complete_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.status == frt_pkg::ST_COMPLETE) |->
			result.message_done && result.accepted)
		else $error("complete status without accepted completion");

	// an accepted fragment that does not complete is ok or restarted
	a_accept_status: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.accepted && !result.message_done |->
			(result.status == frt_pkg::ST_OK) ||
			(result.status == frt_pkg::ST_RESTARTED))
		else $error("accepted fragment with a drop status");

	// register writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid |-> cfg.ready)
		else $error("register write stalled");

endmodule

bind fragment_reassembly_tracker_core frt_checker u_frt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.item   (item),
	.result (result),
	.cfg    (cfg)
);
